// ----- hdl/sldf_pkg.sv -----
// shared types and constants for the sync, length and checksum deframer
package sldf_pkg;

    // result event codes
    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_MISMATCH = 3'd2,
        EV_TOO_LONG = 3'd3,
        EV_ZERO_LEN = 3'd4,
        EV_TIMEOUT  = 3'd5
    } event_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_MAX_LENGTH   = 2'd1,
        CFG_BYTE_TIMEOUT = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    // input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // framing constants
    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [8:0] CHECK_BASE  = 9'h100;

    // register reset values
    localparam logic        ENABLE_RESET       = 1'b1;
    localparam logic [7:0]  MAX_LENGTH_RESET   = 8'd255;
    localparam logic [15:0] BYTE_TIMEOUT_RESET = 16'd1000;

endpackage

// ----- hdl/sync_length_checksum_deframer.sv -----
// serial byte deframer with two-byte sync, length byte, checksum and timeout
//
// Each input item is either a received byte or a timer tick. The block hunts
// for the bytes 0xFF 0x55, takes the next byte as payload length, passes each
// payload byte out with its index, then reports accept or checksum mismatch on
// the checksum byte; a bad length or too many idle ticks aborts the packet.
// An item passes from the input register through the state update into the
// output register. One item can be accepted every cycle while the output is
// not stalled; the input register lets one more item in while a finished
// result waits in the output register. Configuration is taken on every cycle
// (cfg_ready is always high); writes to unknown indexes are ignored.
module sync_length_checksum_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // data[7:0]
    input  logic [0:0]                         s_tuser,   // kind[0]
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // payload_byte[7:0], position[15:8], packet_length[23:16],
    // computed_checksum[31:24]
    output logic [31:0]                        m_tdata,
    output logic [2:0]                         m_tuser,   // event_res[2:0]
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sldf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sldf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sldf_pkg::*;

    // configuration registers
    logic        enable_reg;
    logic [7:0]  max_length_reg;
    logic [15:0] byte_timeout_reg;

    // input register
    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [7:0]  in_data_reg;

    // deframer state
    logic        in_packet_reg,       in_packet_next;
    logic [7:0]  previous_byte_reg,   previous_byte_next;
    logic [7:0]  expected_length_reg, expected_length_next;
    logic [7:0]  byte_count_reg,      byte_count_next;
    logic [7:0]  running_sum_reg,     running_sum_next;
    logic [15:0] idle_ticks_reg,      idle_ticks_next;

    // output register
    logic        out_valid_reg,  out_valid_next;
    event_t      out_event_reg,  out_event_next;
    logic [7:0]  out_byte_reg,   out_byte_next;
    logic [7:0]  out_pos_reg,    out_pos_next;
    logic [7:0]  out_len_reg,    out_len_next;
    logic [7:0]  out_chk_reg,    out_chk_next;

    logic        advance;
    logic        has_result;
    logic [16:0] ticks_inc;
    logic [7:0]  checksum;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign ticks_inc = {1'b0, idle_ticks_reg} + 17'd1;
    assign checksum  = 8'(CHECK_BASE - {1'b0, running_sum_reg});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= ENABLE_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
            byte_timeout_reg <= BYTE_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:       enable_reg       <= cfg_data[0];
                CFG_MAX_LENGTH:   max_length_reg   <= cfg_data[7:0];
                CFG_BYTE_TIMEOUT: byte_timeout_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser[0];
            in_data_reg <= s_tdata;
        end
    end

    // state update and result for the item in the input register
    always_comb
    begin
        in_packet_next       = in_packet_reg;
        previous_byte_next   = previous_byte_reg;
        expected_length_next = expected_length_reg;
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        idle_ticks_next      = idle_ticks_reg;
        has_result           = 1'b0;
        out_event_next       = EV_PAYLOAD;
        out_byte_next        = 8'd0;
        out_pos_next         = 8'd0;
        out_len_next         = expected_length_reg;
        out_chk_next         = 8'd0;

        if (advance && enable_reg)
        begin
            if (in_kind_reg == KIND_TICK)
            begin
                // idle tick inside a packet
                if (in_packet_reg)
                begin
                    if (ticks_inc > {1'b0, byte_timeout_reg})
                    begin
                        in_packet_next = 1'b0;
                        has_result     = 1'b1;
                        out_event_next = EV_TIMEOUT;
                    end
                    else
                    begin
                        idle_ticks_next = ticks_inc[15:0];
                    end
                end
            end
            else
            begin
                previous_byte_next = in_data_reg;
                if (!in_packet_reg)
                begin
                    // sync hunt
                    if (previous_byte_reg == SYNC_FIRST && in_data_reg == SYNC_SECOND)
                    begin
                        in_packet_next       = 1'b1;
                        expected_length_next = 8'd0;
                        byte_count_next      = 8'd0;
                        running_sum_next     = 8'd0;
                        idle_ticks_next      = 16'd0;
                    end
                end
                else
                begin
                    idle_ticks_next = 16'd0;
                    if (expected_length_reg == 8'd0 && byte_count_reg == 8'd0)
                    begin
                        // length byte
                        expected_length_next = in_data_reg;
                        out_len_next         = in_data_reg;
                        if (in_data_reg > max_length_reg)
                        begin
                            in_packet_next = 1'b0;
                            has_result     = 1'b1;
                            out_event_next = EV_TOO_LONG;
                        end
                        else if (in_data_reg == 8'd0)
                        begin
                            in_packet_next = 1'b0;
                            has_result     = 1'b1;
                            out_event_next = EV_ZERO_LEN;
                        end
                        else
                        begin
                            running_sum_next = in_data_reg;
                        end
                    end
                    else if (byte_count_reg < expected_length_reg)
                    begin
                        // payload byte
                        has_result       = 1'b1;
                        out_event_next   = EV_PAYLOAD;
                        out_byte_next    = in_data_reg;
                        out_pos_next     = byte_count_reg;
                        running_sum_next = running_sum_reg + in_data_reg;
                        byte_count_next  = byte_count_reg + 8'd1;
                    end
                    else
                    begin
                        // checksum byte
                        in_packet_next = 1'b0;
                        has_result     = 1'b1;
                        out_event_next = (checksum == in_data_reg) ? EV_ACCEPT : EV_MISMATCH;
                        out_byte_next  = in_data_reg;
                        out_chk_next   = checksum;
                    end
                end
            end
        end
    end

    // output valid
    always_comb
    begin
        if (advance && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg       <= 1'b0;
            previous_byte_reg   <= 8'd0;
            expected_length_reg <= 8'd0;
            byte_count_reg      <= 8'd0;
            running_sum_reg     <= 8'd0;
            idle_ticks_reg      <= 16'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            in_packet_reg       <= in_packet_next;
            previous_byte_reg   <= previous_byte_next;
            expected_length_reg <= expected_length_next;
            byte_count_reg      <= byte_count_next;
            running_sum_reg     <= running_sum_next;
            idle_ticks_reg      <= idle_ticks_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_event_reg <= out_event_next;
            out_byte_reg  <= out_byte_next;
            out_pos_reg   <= out_pos_next;
            out_len_reg   <= out_len_next;
            out_chk_reg   <= out_chk_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {out_chk_reg, out_len_reg, out_pos_reg, out_byte_reg};

    // any verdict or abort closes the packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result && out_event_next != EV_PAYLOAD) |=> !in_packet_reg)
        else $error("packet still open after a verdict or abort");

    // payload count never passes the length
    assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg |-> (byte_count_reg <= expected_length_reg))
        else $error("byte count beyond packet length");

    // a payload result carries an index inside the packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == EV_PAYLOAD) |-> (out_pos_reg < out_len_reg))
        else $error("payload index outside packet");

    // accept means the checksum byte matched
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == EV_ACCEPT) |-> (out_byte_reg == out_chk_reg))
        else $error("accept with mismatched checksum");

endmodule
